/* rtl/swr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

  localparam int unsigned PAT_LEN    = 5;
  localparam int unsigned REP_LEN    = 6;
  localparam int unsigned QDEPTH_DEF = 4;

  // One classified input byte: held prefix, then the byte itself or the
  // replacement word, then the prefix flushed at end of text.
  typedef struct packed {
    logic [2:0] pre_len;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       has_rep;
    logic [2:0] post_len;
    logic       last;
  } swr_cmd_t;

  localparam int unsigned CMD_W = $bits(swr_cmd_t);

  function automatic logic [7:0] pat_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h42; // B
      3'd1:    b = 8'h41; // A
      3'd2:    b = 8'h53; // S
      3'd3:    b = 8'h49; // I
      3'd4:    b = 8'h43; // C
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h44; // D
      3'd1:    b = 8'h65; // e
      3'd2:    b = 8'h6c; // l
      3'd3:    b = 8'h70; // p
      3'd4:    b = 8'h68; // h
      3'd5:    b = 8'h69; // i
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] cmd_len(input swr_cmd_t c);
    logic [3:0] n;
    n = {1'b0, c.pre_len} + {3'b000, c.has_byte} + {1'b0, c.post_len}
        + (c.has_rep ? 4'(REP_LEN) : 4'd0);
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/swr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module swr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // [7:0] text_byte
  input  wire logic            in_tlast,   // end_of_text
  input  wire logic            q_full,
  output logic                 q_push,
  output swr_pkg::swr_cmd_t    q_cmd
);
  import swr_pkg::*;

  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] idx;
  logic [2:0] newc;
  logic       accept;
  swr_cmd_t   cmd;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    idx  = (cnt_r > 3'(PAT_LEN - 1)) ? 3'(PAT_LEN - 1) : cnt_r;
    cmd  = '0;
    newc = 3'd0;
    cmd.data_byte = in_tdata;
    cmd.last      = in_tlast;
    if (in_tdata == pat_byte(idx)) begin
      newc = idx + 3'd1;
      if (newc == 3'(PAT_LEN)) begin
        cmd.has_rep = 1'b1;
        newc        = 3'd0;
      end
    end else begin
      // flush the held prefix, then test this byte as a new start
      cmd.pre_len = idx;
      if (in_tdata == pat_byte(3'd0)) begin
        newc = 3'd1;
      end else begin
        cmd.has_byte = 1'b1;
      end
    end
    if (in_tlast) begin
      cmd.post_len = newc;
      newc         = 3'd0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd_len(cmd) != 4'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = newc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/swr_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module swr_cmd_fifo #(
  parameter int unsigned DEPTH = swr_pkg::QDEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire swr_pkg::swr_cmd_t  push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output logic                    valid,
  output swr_pkg::swr_cmd_t       head
);
  import swr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  swr_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/swr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module swr_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire swr_pkg::swr_cmd_t  q_cmd,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [7:0] out_byte
  output logic                    out_tlast   // out_last
);
  import swr_pkg::*;

  swr_cmd_t   cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [3:0] j_r, j_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r;
  logic       ol_r;
  logic [3:0] len;
  logic [3:0] k1, k2, k3;
  logic [7:0] sel;
  logic       emit, done, load;

  assign len  = cmd_len(cur_r);
  assign emit = cur_vld_r && (!ov_r || out_tready);
  assign done = emit && (j_r == len - 4'd1);
  assign load = q_valid && (!cur_vld_r || done);
  assign q_pop = load;

  // walk the segments: held prefix, byte or replacement, trailing flush
  always_comb begin
    k1  = j_r - {1'b0, cur_r.pre_len};
    k2  = k1 - {3'b000, cur_r.has_byte};
    k3  = k2 - (cur_r.has_rep ? 4'(REP_LEN) : 4'd0);
    if (j_r < {1'b0, cur_r.pre_len}) begin
      sel = pat_byte(j_r[2:0]);
    end else if (cur_r.has_byte && (k1 == 4'd0)) begin
      sel = cur_r.data_byte;
    end else if (cur_r.has_rep && (k2 < 4'(REP_LEN))) begin
      sel = rep_byte(k2[2:0]);
    end else begin
      sel = pat_byte(k3[2:0]);
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    j_nxt       = j_r;
    if (load) begin
      cur_nxt     = q_cmd;
      cur_vld_nxt = 1'b1;
      j_nxt       = 4'd0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
    end else if (emit) begin
      j_nxt = j_r + 4'd1;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    j_r   <= j_nxt;
    if (emit) begin
      od_r <= sel;
      ol_r <= cur_r.last && (j_r == len - 4'd1);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

`default_nettype wire

/* rtl/stream_word_replace.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata          | tlast        | Role
// in_     | in  | [7:0] text_byte | end_of_text | text bytes to scan
// out_    | out | [7:0] out_byte  | out_last    | rewritten text bytes
//
// A byte is classified on transfer and queued as a command if it releases
// output; n = 0 to 6 released bytes leave one per cycle when not stalled
// by out_tready, via the queue, command register and output register.
// Reset (synchronous, rst_n low) clears the match count, queue and output.
// The input stalls only when the command queue is full; out_tready low
// holds the output register and lets the queue fill.

module stream_word_replace #(
  parameter int unsigned QDEPTH = swr_pkg::QDEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // out_last
);
  import swr_pkg::*;

  swr_cmd_t push_cmd;
  swr_cmd_t head;
  logic     push, full, pop, q_valid;

  swr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  swr_cmd_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  swr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import swr_pkg::PAT_LEN;
  import swr_pkg::REP_LEN;

  localparam logic [8*PAT_LEN-1:0] FIND_WORD = "BASIC";
  localparam logic [8*REP_LEN-1:0] SUB_WORD  = "Delphi";
  localparam int unsigned DIRECTED_BYTES = 24;
  localparam int unsigned TOTAL_BYTES    = 356;
  localparam int unsigned HOLD_AFTER     = 150;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] text_byte
  logic       in_tlast = 1'b0;   // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;         // out_last

  text_beat_t pending_text[$];
  text_beat_t rewritten_bytes[$];
  logic [2:0] held_cnt = 3'd0;
  logic       in_took = 1'b0;
  logic       rx_holding = 1'b0;
  int         accepted_bytes = 0;
  int         mismatches = 0;

  stream_word_replace uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] find_byte(input logic [2:0] k);
    int sh;
    sh = 8 * (int'(PAT_LEN) - 1 - int'(k));
    return FIND_WORD[sh +: 8];
  endfunction

  task automatic push_rewritten(input logic [7:0] b);
    text_beat_t t;
    t.data = b;
    t.last = 1'b0;
    rewritten_bytes.push_back(t);
  endtask

  // Emit the held prefix as plain text.
  task automatic release_held();
    int k;
    for (k = 0; k < int'(held_cnt); k++) push_rewritten(find_byte(k[2:0]));
    held_cnt = 3'd0;
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic last);
    int         n0;
    int         k;
    text_beat_t t;
    n0 = rewritten_bytes.size();
    if (held_cnt > PAT_LEN - 1) held_cnt = 3'(PAT_LEN - 1);
    if (b == find_byte(held_cnt)) begin
      held_cnt = held_cnt + 3'd1;
    end else begin
      release_held();
      // the word has no border, so only the current byte can restart a match
      if (b == find_byte(3'd0)) held_cnt = 3'd1;
      else push_rewritten(b);
    end
    if (held_cnt == PAT_LEN) begin
      for (k = 0; k < int'(REP_LEN); k++) push_rewritten(SUB_WORD[8*(int'(REP_LEN)-1-k) +: 8]);
      held_cnt = 3'd0;
    end
    if (last) begin
      release_held();
      if (rewritten_bytes.size() > n0) begin
        t = rewritten_bytes.pop_back();
        t.last = 1'b1;
        rewritten_bytes.push_back(t);
      end
    end
  endtask

  task automatic add_text(input logic [7:0] b, input logic last);
    text_beat_t t;
    t.data = b;
    t.last = last;
    pending_text.push_back(t);
  endtask

  task automatic add_word(input string s);
    int k;
    for (k = 0; k < s.len(); k++) add_text(s[k], k == s.len() - 1);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin : driver
    static int burst_left = 0;
    static int gap_left = 0;
    if (in_took) void'(pending_text.pop_front());
    if (in_tvalid && !in_took) begin
      // hold the offered transfer until it is taken
    end else if (gap_left > 0 && !rx_holding) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (pending_text.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_text[0].data;
      in_tlast  <= pending_text[0].last;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: stall pattern changes now and then; one long hold-off.
  always @(negedge clk) begin : receiver
    static int       hold_left = 0;
    static logic     hold_done = 1'b0;
    static int       mode_left = 0;
    static int       phase = 0;
    static rx_mode_t mode = RX_OPEN;
    if (mode_left == 0) begin
      mode      = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    phase = (phase + 1) % 5;
    if (hold_left == 0 && !hold_done && accepted_bytes >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_tready <= (phase != 0 && phase != 3);
        default:    out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
    rx_holding <= (hold_left > 0);
  end

  always @(posedge clk) begin : monitor
    text_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rewrite_byte(in_tdata, in_tlast);
        accepted_bytes++;
      end
      if (out_tvalid && out_tready) begin
        if (rewritten_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %h out_last %b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = rewritten_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_tdata);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    in_took <= rst_n && in_tvalid && in_tready;
  end

  initial begin : stimulus
    int         pieces;
    int         k;
    int         j;
    int         total;
    logic [7:0] b;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_word("BASIC");     // match completed by the last byte
    add_word("BASIBASI");  // four held, B restarts; four held flushed at end
    add_word("BASIX");     // mismatch after four held
    add_word("B");         // lone held byte flushed at end
    add_text(8'h00, 1'b1);
    add_text(8'hFF, 1'b1);
    add_word("aBC");
    total = DIRECTED_BYTES;

    // Mostly pattern fragments with random content between them.
    while (total < DIRECTED_BYTES + TOTAL_BYTES) begin
      pieces = $urandom_range(1, 12);
      for (k = 0; k < pieces; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            for (j = 0; j < PAT_LEN; j++) add_text(find_byte(j[2:0]), 1'b0);
            total += PAT_LEN;
          end
          3, 4: begin
            for (j = 0; j < $urandom_range(1, 4); j++) add_text(find_byte(j[2:0]), 1'b0);
            total += j;
          end
          5, 6: begin
            add_text(find_byte(3'($urandom_range(0, 4))), 1'b0);
            total++;
          end
          7: begin
            add_text(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
            total++;
          end
          default: begin
            b = 8'($urandom_range(0, 255));
            add_text(b, 1'b0);
            total++;
          end
        endcase
      end
      add_text(pending_text[$].data, 1'b1);
      void'(pending_text.pop_back());
      pending_text[$] = '{data: pending_text[$].data, last: 1'b1};
    end

    while (pending_text.size() != 0 || in_tvalid) @(posedge clk);
    while (rewritten_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/swr_pkg.sv
rtl/swr_front.sv
rtl/swr_cmd_fifo.sv
rtl/swr_back.sv
rtl/stream_word_replace.sv
tb/testbench.sv
